FILE: rtl/rpsh_pkg.sv
// Shared types and constants for the sign random projection hash.
// Holds the port payload structs, opcodes and the front-to-back command type.
// No dependencies.
`timescale 1ns / 1ps

package rpsh_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned OpW   = 2;
  localparam int unsigned RowW  = 5;
  localparam int unsigned ColW  = 10;
  localparam int unsigned ValW  = 16;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned PidxW = 16;

  // Accumulator width and the shift that aligns a Q4.11 offset to Q.22
  localparam int unsigned AccW     = 48;
  localparam int unsigned ProdW    = 2 * ValW;
  localparam int unsigned OffAlign = 11;

  // Input opcodes
  localparam logic [OpW-1:0] OP_COEF   = 2'd0;
  localparam logic [OpW-1:0] OP_OFFSET = 2'd1;
  localparam logic [OpW-1:0] OP_DATA   = 2'd2;

  typedef enum logic [1:0] {
    CMD_COEF,
    CMD_OFFSET,
    CMD_DATA
  } cmd_kind_e;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [RowW-1:0]        row;
    logic [ColW-1:0]        col;
    logic signed [ValW-1:0] value;
    logic                   last;
  } in_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [PidxW-1:0] point_index;
  } out_t;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    cmd_kind_e              kind;
    logic [RowW-1:0]        row;
    logic [ColW-1:0]        col;
    logic                   col_ok;
    logic signed [ValW-1:0] value;
    logic                   last;
  } cmd_t;

endpackage

FILE: rtl/rpsh_front.sv
// Front end: accepts input transactions, range-checks them and classifies them.
// Drops loads to absent rows or columns and unused opcodes. Uses rpsh_pkg.
`timescale 1ns / 1ps

module rpsh_front import rpsh_pkg::*; #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DIMENSION = 1024
) (
  input  logic start_i,
  input  in_t  item_i,
  input  logic full_i,
  output logic busy_o,
  output logic push_o,
  output cmd_t cmd_o
);

  logic row_ok;
  logic col_ok;
  logic keep;
  cmd_kind_e kind;

  assign row_ok = 32'(item_i.row) < KEY_BITS;
  assign col_ok = 32'(item_i.col) < DIMENSION;

  // Classify by opcode; data always goes through so that last closes the point
  always_comb begin
    keep = 1'b0;
    kind = CMD_DATA;
    case (item_i.op)
      OP_COEF: begin
        keep = row_ok && col_ok;
        kind = CMD_COEF;
      end
      OP_OFFSET: begin
        keep = row_ok;
        kind = CMD_OFFSET;
      end
      OP_DATA: begin
        keep = 1'b1;
        kind = CMD_DATA;
      end
      default: begin
        keep = 1'b0;
        kind = CMD_DATA;
      end
    endcase
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i && keep;

  always_comb begin
    cmd_o.kind   = kind;
    cmd_o.row    = item_i.row;
    cmd_o.col    = item_i.col;
    cmd_o.col_ok = col_ok;
    cmd_o.value  = item_i.value;
    cmd_o.last   = item_i.last;
  end

endmodule

FILE: rtl/rpsh_queue.sv
// Two-entry command queue between the front end and the back end.
// Uses cmd_t from rpsh_pkg.
`timescale 1ns / 1ps

module rpsh_queue import rpsh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output cmd_t data_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/rpsh_back.sv
// Back end: holds the coefficient, offset and accumulator memories and steps
// one shared MAC through the projections of each data element. Uses rpsh_pkg.
`timescale 1ns / 1ps

module rpsh_back import rpsh_pkg::*; #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DIMENSION = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  input  cmd_t cmd_i,
  output logic pop_o,
  output logic result_valid_o,
  output out_t result_o
);

  localparam int unsigned RW        = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned CW        = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
  localparam int unsigned CoefDepth = KEY_BITS * (2 ** CW);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Memories
  logic signed [ValW-1:0] coef_mem [CoefDepth];
  logic signed [ValW-1:0] off_mem  [KEY_BITS];
  logic [AccW-1:0]        acc_mem  [KEY_BITS];

  logic [1:0]  state_q, state_d;
  logic [RW-1:0] cnt_q, cnt_d;
  logic [KEY_BITS-1:0] acc_vld_q, acc_vld_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [PidxW-1:0] pcnt_q, pcnt_d;
  logic res_valid_q, res_valid_d;
  out_t res_q, res_d;

  // Element being processed
  logic [CW-1:0]          cur_col_q;
  logic signed [ValW-1:0] cur_val_q;
  logic                   cur_ok_q;
  logic                   cur_last_q;
  logic                   load_cur;

  // Pipeline
  logic p1_v_q, p2_v_q, p3_v_q;
  logic [RW-1:0] p1_idx_q, p2_idx_q, p3_idx_q;
  logic signed [ValW-1:0] coef_rd_q, off_rd_q, off2_q, off3_q;
  logic [AccW-1:0] acc_rd_q, acc_b_q, sum_q, acc_sum;
  logic p1_avld_q;
  logic signed [ProdW-1:0] prod_q;
  logic [AccW:0] total;
  logic [31:0] p3_idx_ext;

  logic issue, finish, pipe_busy;
  logic coef_we, off_we;
  logic [31:0] row_ext, col_ext;
  logic [RW-1:0] head_row;
  logic [CW-1:0] head_col;

  assign row_ext  = 32'(cmd_i.row);
  assign col_ext  = 32'(cmd_i.col);
  assign head_row = row_ext[RW-1:0];
  assign head_col = col_ext[CW-1:0];

  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign coef_we   = pop_o && (cmd_i.kind == CMD_COEF);
  assign off_we    = pop_o && (cmd_i.kind == CMD_OFFSET);
  assign load_cur  = pop_o && (cmd_i.kind == CMD_DATA);
  assign issue     = state_q == ST_RUN;
  assign pipe_busy = p1_v_q || p2_v_q || p3_v_q;
  assign finish    = (state_q == ST_DRAIN) && !pipe_busy;

  // Accumulate and sign test
  assign acc_sum    = acc_b_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign total      = {sum_q[AccW-1], sum_q}
                    + {{(AccW+1-ValW-OffAlign){off3_q[ValW-1]}}, off3_q, {OffAlign{1'b0}}};
  assign p3_idx_ext = 32'(p3_idx_q);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_vld_d   = acc_vld_q;
    key_d       = key_q;
    pcnt_d      = pcnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    case (state_q)
      ST_IDLE: begin
        if (load_cur) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + RW'(1);
        if (cnt_q == RW'(KEY_BITS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (p2_v_q) begin
      acc_vld_d[p2_idx_q] = 1'b1;
    end
    if (p3_v_q && cur_last_q && (p3_idx_ext < KeyW)) begin
      key_d[p3_idx_ext[4:0]] = ~total[AccW];
    end

    // Close the point: emit the key and restart the accumulators
    if (finish && cur_last_q) begin
      res_valid_d       = 1'b1;
      res_d.key         = key_q;
      res_d.point_index = pcnt_q;
      pcnt_d            = pcnt_q + PidxW'(1);
      key_d             = '0;
      acc_vld_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_vld_q   <= '0;
      key_q       <= '0;
      pcnt_q      <= '0;
      res_valid_q <= 1'b0;
      cur_last_q  <= 1'b0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_vld_q   <= acc_vld_d;
      key_q       <= key_d;
      pcnt_q      <= pcnt_d;
      res_valid_q <= res_valid_d;
      p1_v_q      <= issue;
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      if (load_cur) begin
        cur_last_q <= cmd_i.last;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (load_cur) begin
      cur_col_q <= head_col;
      cur_val_q <= cmd_i.value;
      cur_ok_q  <= cmd_i.col_ok;
    end
    p1_idx_q  <= cnt_q;
    p1_avld_q <= acc_vld_q[cnt_q];
    p2_idx_q  <= p1_idx_q;
    prod_q    <= cur_ok_q ? ProdW'(cur_val_q * coef_rd_q) : '0;
    acc_b_q   <= p1_avld_q ? acc_rd_q : '0;
    off2_q    <= off_rd_q;
    p3_idx_q  <= p2_idx_q;
    sum_q     <= acc_sum;
    off3_q    <= off2_q;
  end

  // Coefficient memory
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[{head_row, head_col}] <= cmd_i.value;
    end
    if (issue) begin
      coef_rd_q <= coef_mem[{cnt_q, cur_col_q}];
    end
  end

  // Offset memory
  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[head_row] <= cmd_i.value;
    end
    if (issue) begin
      off_rd_q <= off_mem[cnt_q];
    end
  end

  // Accumulator memory
  always_ff @(posedge clk_i) begin
    if (p2_v_q) begin
      acc_mem[p2_idx_q] <= acc_sum;
    end
    if (issue) begin
      acc_rd_q <= acc_mem[cnt_q];
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

FILE: rtl/random_projection_sign_hash.sv
// A closing data element gives its result strobe once the back end has stepped
// through all of its projections; loads are written as they leave the queue.
// The back end pops no new command while it steps the single shared MAC through the
// projections of an element; a two-entry queue absorbs input meanwhile.
// Reset clears the accumulators and point counter; tables hold garbage until loaded.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`timescale 1ns / 1ps

module random_projection_sign_hash import rpsh_pkg::*; #(
  parameter int unsigned KEY_BITS  = 32,
  parameter int unsigned DIMENSION = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic result_valid_o,
  output out_t result_o
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  rpsh_front #(
    .KEY_BITS (KEY_BITS),
    .DIMENSION(DIMENSION)
  ) u_front (
    .start_i(start),
    .item_i (item_i),
    .full_i (q_full),
    .busy_o (busy),
    .push_o (q_push),
    .cmd_o  (q_wdata)
  );

  rpsh_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .full_o (q_full),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  rpsh_back #(
    .KEY_BITS (KEY_BITS),
    .DIMENSION(DIMENSION)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .cmd_i         (q_rdata),
    .pop_o         (q_pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

FILE: rtl/rpsh_checker.sv
// Port-level checks for random_projection_sign_hash, attached by bind.
// Uses rpsh_pkg for the payload types.
`timescale 1ns / 1ps

module rpsh_checker import rpsh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic result_valid_o,
  input out_t result_o
);

  logic [2:0]       pending_q;
  logic [PidxW-1:0] exp_idx_q;
  logic             closes;

  assign closes = start && !busy && (item_i.op == OP_DATA) && item_i.last;

  // Track closing transactions still owed a result, and the expected index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      exp_idx_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(closes) - 3'(result_valid_o);
      if (result_valid_o) begin
        exp_idx_q <= exp_idx_q + PidxW'(1);
      end
    end
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_result_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (pending_q != 3'd0))
    else $error("result without a closing data transaction");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.point_index == exp_idx_q))
    else $error("point index out of sequence");

  a_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == 3'd0 && !closes) |=> !result_valid_o)
    else $error("result with no point outstanding");

endmodule

bind random_projection_sign_hash rpsh_checker u_rpsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .item_i        (item_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
